// ===== src/bsfh_pkg.sv =====
// Package for the byte stream statistics block: item types, opcodes and constants.
// It also holds the FNV-1a step and the byte classifier used by the top level.
// It has no dependencies.
package bsfh_pkg;

  localparam int COUNT_BITS = 40;
  localparam int OUT_BITS   = 40;

  localparam logic [63:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
  // The FNV prime is 2^40 + 0x1B3, so the product splits into a shift and a small multiply.
  localparam int          PRIME_SHIFT = 40;
  localparam logic [8:0]  PRIME_LOW   = 9'h1B3;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  localparam logic OP_DATA   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] byte_total;
    logic [OUT_BITS-1:0] line_total;
    logic [OUT_BITS-1:0] printable_total;
    logic [7:0]          top_byte;
    logic [OUT_BITS-1:0] top_byte_count;
    logic [63:0]         digest;
  } out_item_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out(input cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_BITS-1:0];
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return (b == CHAR_TAB) || (b == CHAR_LF) || (b == CHAR_CR) ||
           ((b >= CHAR_SPACE) && (b <= CHAR_TILDE));
  endfunction

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << PRIME_SHIFT) + (x * {55'd0, PRIME_LOW});
  endfunction

endpackage

// ===== src/bsfh_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Reading an address in the cycle it is written returns the old data.
// No dependencies.
module bsfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/byte_stream_stats_fnv1a_hash.sv =====
// Byte stream statistics: FNV-1a 64-bit digest, byte histogram and counters.
// Depends on bsfh_pkg and bsfh_ram.
//
// The block takes one item per clock cycle, unless stalled, as a data byte or a finish
// command. A data byte is registered while its histogram entry is read from a
// 256-entry RAM, and in the next cycle the entry is incremented and written back,
// with the previous write forwarded when two bytes in a row hit the same entry;
// that read-modify-write loop, together with the hash update, sets the rate of one
// byte per cycle unless a finish waits on an untaken result. A finish passes stage 1
// and its result is registered; the next stream may follow at once. All counters,
// the hash and the histogram return to their reset values in the same cycle the
// result is captured: per-entry valid flops clear the histogram at once, so no
// clearing pass is needed after reset or finish. Counts saturate at all ones.
module byte_stream_stats_fnv1a_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsfh_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bsfh_pkg::out_item_t out_item
);
  import bsfh_pkg::*;

  // Stage 1 holds the item whose histogram entry is arriving from the RAM.
  logic        s1_vld_r, s1_vld_nxt;
  logic        s1_op_r;
  logic [7:0]  s1_byte_r;

  logic        fwd_vld_r, fwd_vld_nxt;
  logic [7:0]  fwd_addr_r;
  cnt_t        fwd_data_r;

  logic [255:0] hist_vld_r, hist_vld_nxt;

  cnt_t        total_r, total_nxt;
  cnt_t        line_r, line_nxt;
  cnt_t        print_r, print_nxt;
  cnt_t        best_cnt_r, best_cnt_nxt;
  logic [7:0]  best_sym_r, best_sym_nxt;
  logic [63:0] hash_r, hash_nxt;

  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_item_r;

  logic        stall, byte_go, fin_go;
  logic [7:0]  ram_raddr;
  cnt_t        ram_rdata, hist_old, hist_new;

  assign stall   = s1_vld_r && (s1_op_r == OP_FINISH) && out_vld_r && !out_ready;
  assign byte_go = s1_vld_r && !stall && (s1_op_r == OP_DATA);
  assign fin_go  = s1_vld_r && !stall && (s1_op_r == OP_FINISH);
  assign in_ready = !stall;

  assign ram_raddr = in_ready ? in_item.data_byte : s1_byte_r;

  bsfh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (256)
  ) u_hist_ram (
    .clk   (clk),
    .we    (byte_go),
    .waddr (s1_byte_r),
    .wdata (hist_new),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    priority if (fwd_vld_r && (fwd_addr_r == s1_byte_r)) begin
      hist_old = fwd_data_r;
    end else if (hist_vld_r[s1_byte_r]) begin
      hist_old = ram_rdata;
    end else begin
      hist_old = '0;
    end
    hist_new = sat_inc(hist_old);
  end

  always_comb begin
    s1_vld_nxt   = in_ready ? in_valid : s1_vld_r;
    fwd_vld_nxt  = byte_go;
    hist_vld_nxt = hist_vld_r;
    total_nxt    = total_r;
    line_nxt     = line_r;
    print_nxt    = print_r;
    best_cnt_nxt = best_cnt_r;
    best_sym_nxt = best_sym_r;
    hash_nxt     = hash_r;
    out_vld_nxt  = out_vld_r && !out_ready;

    if (byte_go) begin
      hist_vld_nxt[s1_byte_r] = 1'b1;
      total_nxt = sat_inc(total_r);
      if (s1_byte_r == CHAR_LF) begin
        line_nxt = sat_inc(line_r);
      end
      if (is_printable(s1_byte_r)) begin
        print_nxt = sat_inc(print_r);
      end
      if ((hist_new > best_cnt_r) || ((hist_new == best_cnt_r) && (s1_byte_r < best_sym_r))) begin
        best_cnt_nxt = hist_new;
        best_sym_nxt = s1_byte_r;
      end
      hash_nxt = fnv_step(hash_r, s1_byte_r);
    end

    if (fin_go) begin
      hist_vld_nxt = '0;
      total_nxt    = '0;
      line_nxt     = '0;
      print_nxt    = '0;
      best_cnt_nxt = '0;
      best_sym_nxt = '0;
      hash_nxt     = HASH_BASIS;
      out_vld_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      hist_vld_r <= '0;
      total_r    <= '0;
      line_r     <= '0;
      print_r    <= '0;
      best_cnt_r <= '0;
      best_sym_r <= '0;
      hash_r     <= HASH_BASIS;
      out_vld_r  <= 1'b0;
    end else begin
      s1_vld_r   <= s1_vld_nxt;
      fwd_vld_r  <= fwd_vld_nxt;
      hist_vld_r <= hist_vld_nxt;
      total_r    <= total_nxt;
      line_r     <= line_nxt;
      print_r    <= print_nxt;
      best_cnt_r <= best_cnt_nxt;
      best_sym_r <= best_sym_nxt;
      hash_r     <= hash_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_op_r   <= in_item.opcode;
      s1_byte_r <= in_item.data_byte;
    end
    if (byte_go) begin
      fwd_addr_r <= s1_byte_r;
      fwd_data_r <= hist_new;
    end
    if (fin_go) begin
      out_item_r.byte_total      <= to_out(total_r);
      out_item_r.line_total      <= to_out(line_r);
      out_item_r.printable_total <= to_out(print_r);
      out_item_r.top_byte        <= best_sym_r;
      out_item_r.top_byte_count  <= to_out(best_cnt_r);
      out_item_r.digest          <= hash_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // A finish leaves the block in its reset state and a result waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_vld_r && (total_r == '0) && (hist_vld_r == '0) && (hash_r == HASH_BASIS)))
    else $error("finish did not clear state or present a result");

  // No histogram entry can outgrow the byte count.
  assert property (@(posedge clk) disable iff (!rst_n)
    best_cnt_r <= total_r)
    else $error("dominant byte count exceeds byte total");

  // Newlines are printable, and printable bytes are a subset of all bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    (line_r <= print_r) && (print_r <= total_r))
    else $error("counter ordering violated");

  // A waiting result that is not taken holds a finish behind it and the input, so it is not overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready && s1_vld_r && (s1_op_r == OP_FINISH)) |=> $stable(out_item_r))
    else $error("pending result overwritten");

endmodule
